// File: src/rbcl_pkg.sv
// Shared types and constants for the run-based component labeling block.
// Used by run_based_component_labeling and the testbench; depends on nothing.
`timescale 1ns / 1ps

package rbcl_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int MAX_LABELS = 32768;

    localparam int COL_W = 8;   // column index
    localparam int ROW_W = 8;   // row index
    localparam int DIM_W = 9;   // frame size registers
    localparam int SEG_W = 9;   // segment counter / relative label
    localparam int PAIR_W = 7;  // segment pair index within a row
    localparam int LBL_W = 15;  // label in the equivalence table
    localparam int NL_W  = 16;  // label counter, holds MAX_LABELS itself

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [0:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [0:0] REG_FRAME_HEIGHT = 1'b1;

    typedef struct packed {
        logic       operation;
        logic       pixel_value;
        logic [7:0] read_row;
        logic [7:0] read_column;
    } rbcl_in_t;

    typedef struct packed {
        logic [15:0] pixel_label;
        logic [15:0] component_count;
        logic        frame_done;
    } rbcl_out_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ROWEND,
        ST_SEG_A,
        ST_SEG_B,
        ST_SEG_C,
        ST_SEG_D,
        ST_SEG_E,
        ST_MAP_W,
        ST_FIND,
        ST_WRMAP,
        ST_NEWLBL,
        ST_RES_A,
        ST_RES_B,
        ST_RES_C,
        ST_RD_B,
        ST_RD_C,
        ST_RD_D,
        ST_EMIT
    } rbcl_state_t;

endpackage

// File: src/run_based_component_labeling.sv
// Top level of the run-based 8-connected component labeling block.
// Depends on rbcl_pkg and on rbcl_ram for the four label stores.
//
//  Channel   Direction  Handshake            Payload
//  in        in         in_valid / in_stall  rbcl_in_t (push pixel or read label)
//  out       out        out_valid/out_stall  rbcl_out_t (label, count, frame done)
//  cfg       in         cfg_we               cfg_index, cfg_data (frame size)
//
// At the end of a row every segment pair is linked to the previous row, with
// a root search per overlapped segment, all through the single read port of
// the equivalence table. The last row is followed by the table flattening
// pass over every label. A read of a foreground pixel of a resolved frame
// goes through the relative label, label map and equivalence table. Reset
// leaves the label stores undefined; they are always written before they are
// read. A stalled output holds the sequencer in its final state, and the
// input is stalled whenever the sequencer is not idle.
`timescale 1ns / 1ps

module run_based_component_labeling (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  rbcl_pkg::rbcl_in_t in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output rbcl_pkg::rbcl_out_t out_data,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [8:0]         cfg_data
);

    import rbcl_pkg::*;

    rbcl_state_t state_reg, state_next;

    // Configuration and raster position.
    logic [DIM_W-1:0] width_reg, height_reg;
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;

    // Run detector.
    logic             prev_reg;
    logic [SEG_W-1:0] seg_reg;

    // Labeling state.
    logic [NL_W-1:0]  next_label_reg;
    logic [NL_W-1:0]  resolved_reg;
    logic             resolved_flag_reg;

    // Row linking working registers.
    logic [ROW_W-1:0] lrow_reg;
    logic             lastrow_reg;
    logic [COL_W-1:0] pair_reg;
    logic [COL_W-1:0] j0_reg, j1_reg;
    logic [SEG_W-1:0] e0raw_reg;
    logic [COL_W-1:0] m_reg, m1_reg;
    logic [LBL_W-1:0] x_reg, a_reg;
    logic             first_reg;

    // Resolution pass.
    logic [NL_W-1:0]  idx_reg, cnt_reg;

    // Read operation.
    logic [ROW_W-1:0] rrow_reg;
    logic [COL_W-1:0] rcol_reg;

    // Result.
    logic [15:0]      res_label_reg;
    logic             res_done_reg;
    logic             out_valid_reg;
    rbcl_out_t        out_data_reg;

    // Memory ports.
    logic              rel_we, bnd_we, map_we, eq_we;
    logic [15:0]       rel_waddr, rel_raddr;
    logic [SEG_W-1:0]  rel_wdata, rel_rdata;
    logic [8:0]        bnd_waddr, bnd_raddr;
    logic [COL_W-1:0]  bnd_wdata, bnd_rdata;
    logic [14:0]       map_waddr, map_raddr;
    logic [LBL_W-1:0]  map_wdata, map_rdata;
    logic [LBL_W-1:0]  eq_waddr, eq_raddr, eq_wdata, eq_rdata;

    rbcl_ram #(.AW(16), .DW(SEG_W)) u_rel (
        .clk(clk), .we(rel_we), .waddr(rel_waddr), .wdata(rel_wdata),
        .raddr(rel_raddr), .rdata(rel_rdata)
    );
    rbcl_ram #(.AW(9), .DW(COL_W)) u_bnd (
        .clk(clk), .we(bnd_we), .waddr(bnd_waddr), .wdata(bnd_wdata),
        .raddr(bnd_raddr), .rdata(bnd_rdata)
    );
    rbcl_ram #(.AW(15), .DW(LBL_W)) u_map (
        .clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
        .raddr(map_raddr), .rdata(map_rdata)
    );
    rbcl_ram #(.AW(15), .DW(LBL_W)) u_eq (
        .clk(clk), .we(eq_we), .waddr(eq_waddr), .wdata(eq_wdata),
        .raddr(eq_raddr), .rdata(eq_rdata)
    );

    // Effective frame size: zero counts as one, large values saturate.
    logic [DIM_W-1:0] w_eff, h_eff;
    always_comb
    begin
        if (width_reg == '0)
            w_eff = DIM_W'(1);
        else if (width_reg > DIM_W'(MAX_WIDTH))
            w_eff = DIM_W'(MAX_WIDTH);
        else
            w_eff = width_reg;
        if (height_reg == '0)
            h_eff = DIM_W'(1);
        else if (height_reg > DIM_W'(MAX_HEIGHT))
            h_eff = DIM_W'(MAX_HEIGHT);
        else
            h_eff = height_reg;
    end

    logic accept;
    logic col_last, row_last;
    assign accept   = (state_reg == ST_IDLE) && in_valid;
    assign col_last = ({1'b0, col_reg} + DIM_W'(1)) == w_eff;
    assign row_last = ({1'b0, row_reg} + DIM_W'(1)) == h_eff;

    // Run detector for the incoming pixel; a new row starts with background.
    logic             prev_eff, trans, seg_wr;
    logic [SEG_W-1:0] seg_base, seg_new;
    assign prev_eff = (col_reg == '0) ? 1'b0 : prev_reg;
    assign seg_base = (col_reg == '0) ? '0 : seg_reg;
    assign trans    = in_data.pixel_value != prev_eff;
    assign seg_wr   = trans && (seg_base <= SEG_W'(MAX_WIDTH));
    assign seg_new  = seg_base + SEG_W'(seg_wr);

    // Closing a run that reaches the right edge.
    logic             close_wr;
    logic [SEG_W-1:0] nseg;
    assign close_wr = prev_reg && (seg_reg <= SEG_W'(MAX_WIDTH));
    assign nseg     = seg_reg + SEG_W'(close_wr);

    // Next segment pair: continue while 2*pair+1 is below the segment count.
    logic [COL_W-1:0] pair_inc;
    logic             pair_more;
    assign pair_inc  = pair_reg + COL_W'(1);
    assign pair_more = {pair_inc, 1'b1} < seg_reg;

    // Overlap window in the previous row's relative labels.
    logic [9:0]       e0, e1;
    logic             overlap;
    logic [COL_W-1:0] m0, m1;
    always_comb
    begin
        e0 = e0raw_reg[0] ? {1'b0, e0raw_reg} : ({1'b0, e0raw_reg} + 10'd1);
        e1 = rel_rdata[0] ? {1'b0, rel_rdata} : ({1'b0, rel_rdata} - 10'd1);
        if (e1 > 10'(MAX_WIDTH))
            e1 = 10'(MAX_WIDTH);
        overlap = (rel_rdata != '0) && (e1 >= e0);
        m0 = COL_W'((e0 - 10'd1) >> 1);
        m1 = COL_W'((e1 - 10'd1) >> 1);
    end

    logic [COL_W-1:0] j1_adj;
    assign j1_adj = (({1'b0, bnd_rdata} + DIM_W'(1)) < w_eff) ? (bnd_rdata + COL_W'(1))
                                                              : bnd_rdata;

    logic             find_step, find_last;
    assign find_step = eq_rdata < x_reg;
    assign find_last = m_reg == m1_reg;

    logic             lbl_full;
    logic [LBL_W-1:0] lbl_new;
    assign lbl_full = next_label_reg >= NL_W'(MAX_LABELS);
    assign lbl_new  = lbl_full ? LBL_W'(MAX_LABELS - 1) : next_label_reg[LBL_W-1:0];

    logic res_end, res_ptr;
    assign res_end = idx_reg == next_label_reg;
    assign res_ptr = eq_rdata < idx_reg[LBL_W-1:0];

    logic rd_ok;
    assign rd_ok = resolved_flag_reg && ({1'b0, rrow_reg} < h_eff)
                   && ({1'b0, rcol_reg} < w_eff) && rel_rdata[0]
                   && (rel_rdata <= SEG_W'(MAX_WIDTH));

    logic emit_go;
    assign emit_go = !out_valid_reg || !out_stall;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_data.operation == OP_READ)
                        state_next = ST_RD_B;
                    else if (col_last)
                        state_next = ST_ROWEND;
                    else
                        state_next = ST_EMIT;
                end
            end
            ST_ROWEND:
            begin
                if (SEG_W'(1) < nseg)
                    state_next = ST_SEG_A;
                else if (lastrow_reg)
                    state_next = ST_RES_A;
                else
                    state_next = ST_EMIT;
            end
            ST_SEG_A:  state_next = (lrow_reg == '0) ? ST_NEWLBL : ST_SEG_B;
            ST_SEG_B:  state_next = ST_SEG_C;
            ST_SEG_C:  state_next = ST_SEG_D;
            ST_SEG_D:  state_next = ST_SEG_E;
            ST_SEG_E:  state_next = overlap ? ST_MAP_W : ST_NEWLBL;
            ST_MAP_W:  state_next = ST_FIND;
            ST_FIND:
            begin
                if (find_step)
                    state_next = ST_FIND;
                else if (find_last)
                    state_next = ST_WRMAP;
                else
                    state_next = ST_MAP_W;
            end
            ST_WRMAP, ST_NEWLBL:
            begin
                if (pair_more)
                    state_next = ST_SEG_A;
                else if (lastrow_reg)
                    state_next = ST_RES_A;
                else
                    state_next = ST_EMIT;
            end
            ST_RES_A:  state_next = res_end ? ST_EMIT : ST_RES_B;
            ST_RES_B:  state_next = res_ptr ? ST_RES_C : ST_RES_A;
            ST_RES_C:  state_next = ST_RES_A;
            ST_RD_B:   state_next = rd_ok ? ST_RD_C : ST_EMIT;
            ST_RD_C:   state_next = ST_RD_D;
            ST_RD_D:   state_next = ST_EMIT;
            ST_EMIT:   state_next = emit_go ? ST_IDLE : ST_EMIT;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Memory port control.
    always_comb
    begin
        rel_we    = 1'b0;
        rel_waddr = {row_reg, col_reg};
        rel_wdata = seg_new;
        rel_raddr = {rrow_reg, rcol_reg};
        bnd_we    = 1'b0;
        bnd_waddr = seg_base;
        bnd_wdata = in_data.pixel_value ? col_reg : (col_reg - COL_W'(1));
        bnd_raddr = {pair_reg, 1'b0};
        map_we    = 1'b0;
        map_waddr = {lrow_reg, pair_reg[PAIR_W-1:0]};
        map_wdata = a_reg;
        map_raddr = {lrow_reg - ROW_W'(1), m_reg[PAIR_W-1:0]};
        eq_we     = 1'b0;
        eq_waddr  = idx_reg[LBL_W-1:0];
        eq_wdata  = cnt_reg[LBL_W-1:0];
        eq_raddr  = idx_reg[LBL_W-1:0];
        unique case (state_reg)
            ST_IDLE:
            begin
                rel_raddr = {in_data.read_row, in_data.read_column};
                if (accept && in_data.operation == OP_PUSH)
                begin
                    rel_we = 1'b1;
                    bnd_we = seg_wr;
                end
            end
            ST_ROWEND:
            begin
                bnd_we    = close_wr;
                bnd_waddr = seg_reg;
                bnd_wdata = COL_W'(w_eff - DIM_W'(1));
            end
            ST_SEG_B:
            begin
                bnd_raddr = {pair_reg, 1'b1};
            end
            ST_SEG_C:
            begin
                rel_raddr = {lrow_reg - ROW_W'(1), j0_reg};
            end
            ST_SEG_D:
            begin
                rel_raddr = {lrow_reg - ROW_W'(1), j1_reg};
            end
            ST_SEG_E:
            begin
                map_raddr = {lrow_reg - ROW_W'(1), m0[PAIR_W-1:0]};
            end
            ST_MAP_W:
            begin
                eq_raddr = map_rdata;
            end
            ST_FIND:
            begin
                eq_raddr  = eq_rdata;
                map_raddr = {lrow_reg - ROW_W'(1), pair_inc_m()};
                if (!find_step && !first_reg)
                begin
                    // Link root to root, the smaller label stays the root.
                    if (a_reg < x_reg)
                    begin
                        eq_we    = 1'b1;
                        eq_waddr = x_reg;
                        eq_wdata = a_reg;
                    end
                    else if (x_reg < a_reg)
                    begin
                        eq_we    = 1'b1;
                        eq_waddr = a_reg;
                        eq_wdata = x_reg;
                    end
                end
            end
            ST_WRMAP:
            begin
                map_we = 1'b1;
            end
            ST_NEWLBL:
            begin
                map_we    = 1'b1;
                map_wdata = lbl_new;
                eq_we     = !lbl_full;
                eq_waddr  = lbl_new;
                eq_wdata  = lbl_new;
            end
            ST_RES_B:
            begin
                eq_raddr = eq_rdata;
                eq_we    = !res_ptr;
            end
            ST_RES_C:
            begin
                eq_we    = 1'b1;
                eq_wdata = eq_rdata;
            end
            ST_RD_B:
            begin
                map_raddr = {rrow_reg, rel_rdata[PAIR_W:1]};
            end
            ST_RD_C:
            begin
                eq_raddr = map_rdata;
            end
            default:
            begin
            end
        endcase
    end

    function automatic logic [PAIR_W-1:0] pair_inc_m();
        logic [COL_W-1:0] t;
        t = m_reg + COL_W'(1);
        return t[PAIR_W-1:0];
    endfunction

    // Registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            width_reg         <= DIM_W'(MAX_WIDTH);
            height_reg        <= DIM_W'(MAX_HEIGHT);
            col_reg           <= '0;
            row_reg           <= '0;
            prev_reg          <= 1'b0;
            seg_reg           <= '0;
            next_label_reg    <= '0;
            resolved_reg      <= '0;
            resolved_flag_reg <= 1'b0;
            lrow_reg          <= '0;
            lastrow_reg       <= 1'b0;
            pair_reg          <= '0;
            j0_reg            <= '0;
            j1_reg            <= '0;
            e0raw_reg         <= '0;
            m_reg             <= '0;
            m1_reg            <= '0;
            x_reg             <= '0;
            a_reg             <= '0;
            first_reg         <= 1'b0;
            idx_reg           <= '0;
            cnt_reg           <= '0;
            rrow_reg          <= '0;
            rcol_reg          <= '0;
            res_label_reg     <= '0;
            res_done_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            out_data_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            if (cfg_we && cfg_index[1] == 1'b0)
            begin
                if (cfg_index[0] == REG_FRAME_WIDTH)
                    width_reg <= cfg_data;
                else
                    height_reg <= cfg_data;
                col_reg           <= '0;
                row_reg           <= '0;
                resolved_flag_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    res_label_reg <= '0;
                    res_done_reg  <= 1'b0;
                    rrow_reg      <= in_data.read_row;
                    rcol_reg      <= in_data.read_column;
                    if (accept && in_data.operation == OP_PUSH)
                    begin
                        if (row_reg == '0 && col_reg == '0)
                        begin
                            next_label_reg    <= '0;
                            resolved_reg      <= '0;
                            resolved_flag_reg <= 1'b0;
                        end
                        prev_reg    <= in_data.pixel_value;
                        seg_reg     <= seg_new;
                        lrow_reg    <= row_reg;
                        lastrow_reg <= row_last;
                        if (!col_last)
                        begin
                            col_reg <= col_reg + COL_W'(1);
                        end
                        else
                        begin
                            col_reg <= '0;
                            row_reg <= row_last ? '0 : (row_reg + ROW_W'(1));
                        end
                    end
                end
                ST_ROWEND:
                begin
                    seg_reg  <= nseg;
                    pair_reg <= '0;
                    idx_reg  <= '0;
                    cnt_reg  <= '0;
                end
                ST_SEG_B:
                begin
                    j0_reg <= (bnd_rdata == '0) ? '0 : (bnd_rdata - COL_W'(1));
                end
                ST_SEG_C:
                begin
                    j1_reg <= j1_adj;
                end
                ST_SEG_D:
                begin
                    e0raw_reg <= rel_rdata;
                end
                ST_SEG_E:
                begin
                    m_reg     <= m0;
                    m1_reg    <= m1;
                    first_reg <= 1'b1;
                end
                ST_MAP_W:
                begin
                    x_reg <= map_rdata;
                end
                ST_FIND:
                begin
                    if (find_step)
                    begin
                        x_reg <= eq_rdata;
                    end
                    else
                    begin
                        first_reg <= 1'b0;
                        if (first_reg || x_reg < a_reg)
                            a_reg <= x_reg;
                        m_reg <= m_reg + COL_W'(1);
                    end
                end
                ST_WRMAP:
                begin
                    pair_reg <= pair_inc;
                end
                ST_NEWLBL:
                begin
                    pair_reg <= pair_inc;
                    if (!lbl_full)
                        next_label_reg <= next_label_reg + NL_W'(1);
                end
                ST_RES_A:
                begin
                    if (res_end)
                    begin
                        resolved_reg      <= cnt_reg;
                        resolved_flag_reg <= 1'b1;
                        res_done_reg      <= 1'b1;
                    end
                end
                ST_RES_B:
                begin
                    if (!res_ptr)
                    begin
                        cnt_reg <= cnt_reg + NL_W'(1);
                        idx_reg <= idx_reg + NL_W'(1);
                    end
                end
                ST_RES_C:
                begin
                    idx_reg <= idx_reg + NL_W'(1);
                end
                ST_RD_D:
                begin
                    res_label_reg <= {1'b0, eq_rdata} + 16'd1;
                end
                ST_EMIT:
                begin
                    if (emit_go)
                    begin
                        out_valid_reg                <= 1'b1;
                        out_data_reg.pixel_label     <= res_label_reg;
                        out_data_reg.component_count <= resolved_reg;
                        out_data_reg.frame_done      <= res_done_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign in_stall  = state_reg != ST_IDLE;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: src/rbcl_ram.sv
// Simple dual-port RAM: one write port, one read port with registered data.
// Uses no package.
`timescale 1ns / 1ps

module rbcl_ram #(
    parameter int AW = 8,
    parameter int DW = 8
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: dv/tb.sv
// Self-checking testbench for run_based_component_labeling.
// Depends on rbcl_pkg for the payload structs, operation codes and register indexes.
`timescale 1ns / 1ps

module tb;
    import rbcl_pkg::*;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    // One row of the directed stimulus table. A row either carries a transfer
    // or a frame size write. Rows with has_exp set carry a result that is
    // plain to see; all other rows are checked against the label predictor.
    typedef struct {
        row_kind_t  kind;
        rbcl_in_t   item;
        logic       has_exp;
        rbcl_out_t  exp;
        logic [1:0] reg_idx;
        logic [8:0] reg_val;
    } stim_row_t;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int DRAIN_WAIT  = 40;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    rbcl_in_t    in_data;
    logic        out_valid;
    logic        out_stall;
    rbcl_out_t   out_data;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [8:0]  cfg_data;

    run_based_component_labeling u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock: 10 ns period.
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------
    // Label predictor state. This is an independent copy of the block's
    // architectural state: frame size, run coding stores, the union-find
    // table and the acquisition counters.
    // ------------------------------------------------------------------
    logic [8:0] frame_w_reg;
    logic [8:0] frame_h_reg;
    int         run_code   [MAX_HEIGHT][MAX_WIDTH];
    int         run_bound  [MAX_HEIGHT][MAX_WIDTH + 1];
    int         runs_in_row[MAX_HEIGHT];
    int         run_label  [MAX_HEIGHT][MAX_WIDTH + 1];
    int         parent     [MAX_LABELS];
    int         label_ctr;
    int         last_pixel;
    int         run_ctr;
    int         pixel_pos;
    int         comp_count;
    logic       frame_ready;

    rbcl_out_t  expected_q[$];
    int         err_count;
    int         cycle_count;
    logic       idle_on;
    logic       hold_req;

    function automatic int dim_clamp(int v, int top);
        if (v < 1)
            return 1;
        if (v > top)
            return top;
        return v;
    endfunction

    function automatic int root_of(int x);
        if (x >= MAX_LABELS)
            x = 0;
        while (parent[x] < x)
            x = parent[x];
        return x;
    endfunction

    function automatic int fresh_label();
        int l;
        if (label_ctr >= MAX_LABELS)
            return MAX_LABELS - 1;
        l = label_ctr;
        label_ctr++;
        parent[l] = l;
        return l;
    endfunction

    // Joins every run of the finished row to the runs of the row above that
    // touch it diagonally or directly; roots are linked smaller-wins.
    function automatic void join_row(int row, int w);
        int n, k, er, e0, e1, ek, j0, j1, a, r;
        n = runs_in_row[row];
        if (n > MAX_WIDTH + 1)
            n = MAX_WIDTH + 1;
        for (k = 0; k + 1 < n; k += 2)
        begin
            er = k + 1;
            if (row == 0)
            begin
                run_label[row][er] = fresh_label();
                continue;
            end
            j0 = run_bound[row][k];
            j1 = run_bound[row][er];
            if (j0 > 0)
                j0--;
            if (j1 + 1 < w)
                j1++;
            if (j0 >= MAX_WIDTH)
                j0 = MAX_WIDTH - 1;
            if (j1 >= MAX_WIDTH)
                j1 = MAX_WIDTH - 1;
            e0 = run_code[row - 1][j0];
            e1 = run_code[row - 1][j1];
            if (e0 % 2 == 0)
                e0 += 1;
            if (e1 % 2 == 0)
                e1 -= 1;
            if (e1 > MAX_WIDTH)
                e1 = MAX_WIDTH;
            if (e1 >= e0)
            begin
                a = root_of(run_label[row - 1][e0]);
                for (ek = e0 + 2; ek <= e1; ek += 2)
                begin
                    r = root_of(run_label[row - 1][ek]);
                    if (a < r)
                        parent[r] = a;
                    else if (r < a)
                    begin
                        parent[a] = r;
                        a = r;
                    end
                end
                run_label[row][er] = a;
            end
            else
                run_label[row][er] = fresh_label();
        end
    endfunction

    // Flattens the table into dense final labels.
    function automatic void flatten_labels();
        int cnt, i, p;
        cnt = 0;
        for (i = 0; i < label_ctr && i < MAX_LABELS; i++)
        begin
            p = parent[i];
            if (p < i)
                parent[i] = parent[p];
            else
            begin
                parent[i] = cnt;
                cnt++;
            end
        end
        comp_count  = cnt;
        frame_ready = 1'b1;
    endfunction

    function automatic rbcl_out_t label_predict(rbcl_in_t it);
        int w, h, r, c, er, l, p, row, col;
        rbcl_out_t o;
        w = dim_clamp(frame_w_reg, MAX_WIDTH);
        h = dim_clamp(frame_h_reg, MAX_HEIGHT);
        o = '0;
        if (it.operation == OP_READ)
        begin
            r = it.read_row;
            c = it.read_column;
            if (frame_ready && r < h && c < w)
            begin
                er = run_code[r][c];
                if (er % 2 == 1 && er <= MAX_WIDTH)
                begin
                    l = run_label[r][er];
                    if (l >= MAX_LABELS)
                        l = 0;
                    o.pixel_label = 16'(parent[l] + 1);
                end
            end
        end
        else
        begin
            p = it.pixel_value;
            if (pixel_pos >= w * h)
                pixel_pos = 0;
            if (pixel_pos == 0)
            begin
                label_ctr   = 0;
                comp_count  = 0;
                frame_ready = 1'b0;
            end
            row = pixel_pos / w;
            col = pixel_pos % w;
            if (col == 0)
            begin
                last_pixel = 0;
                run_ctr    = 0;
            end
            if (p != last_pixel)
            begin
                if (run_ctr <= MAX_WIDTH)
                begin
                    run_bound[row][run_ctr] = (p != 0) ? col : col - 1;
                    run_ctr++;
                end
                last_pixel = p;
            end
            run_code[row][col] = run_ctr;
            if (col + 1 == w)
            begin
                if (last_pixel != 0 && run_ctr <= MAX_WIDTH)
                begin
                    run_bound[row][run_ctr] = w - 1;
                    run_ctr++;
                end
                runs_in_row[row] = run_ctr;
                join_row(row, w);
            end
            if (col + 1 == w && row + 1 == h)
            begin
                flatten_labels();
                pixel_pos = 0;
                o.frame_done = 1'b1;
            end
            else
                pixel_pos++;
        end
        o.component_count = 16'(comp_count);
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Sender side. Every task starts and ends at a falling edge, so in_valid
    // gets at most one nonblocking assignment per time step.
    // ------------------------------------------------------------------
    task automatic send_item(rbcl_in_t it, logic has_exp, rbcl_out_t exp);
        rbcl_out_t pred;
        while (idle_on && $urandom_range(99) < 10)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_data  <= it;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        // The transfer happened at this edge; predict before the next edge.
        pred = label_predict(it);
        expected_q.push_back(has_exp ? exp : pred);
        @(negedge clk);
    endtask

    task automatic send_push(logic px);
        rbcl_in_t it;
        it = rbcl_in_t'($urandom);
        it.operation   = OP_PUSH;
        it.pixel_value = px;
        send_item(it, 1'b0, '0);
    endtask

    task automatic send_read(int r, int c);
        rbcl_in_t it;
        it = rbcl_in_t'($urandom);
        it.operation   = OP_READ;
        it.read_row    = 8'(r);
        it.read_column = 8'(c);
        send_item(it, 1'b0, '0);
    endtask

    // Lowers valid and waits until the block has returned every result and
    // has had time to finish any trailing work.
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    // Frame size registers may only change while the block is idle.
    task automatic write_reg(logic [1:0] idx, logic [8:0] val);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == {1'b0, REG_FRAME_WIDTH})
            frame_w_reg = val;
        else
            frame_h_reg = val;
        pixel_pos   = 0;
        frame_ready = 1'b0;
    endtask

    // Pushes a whole frame at the current size with the given foreground
    // density in percent, sprinkling a few reads into the acquisition, then
    // reads back labels, mostly inside the frame and now and then anywhere.
    task automatic run_frame(int density, int n_reads);
        int w, h, i;
        w = dim_clamp(frame_w_reg, MAX_WIDTH);
        h = dim_clamp(frame_h_reg, MAX_HEIGHT);
        for (i = 0; i < w * h; i++)
        begin
            if ($urandom_range(99) < 3)
                send_read($urandom_range(h), $urandom_range(w));
            send_push($urandom_range(99) < density);
        end
        for (i = 0; i < n_reads; i++)
        begin
            if ($urandom_range(9) == 0)
                send_read($urandom_range(255), $urandom_range(255));
            else
                send_read($urandom_range(h - 1), $urandom_range(w - 1));
        end
    endtask

    // Receiver side: random stalls, and a long hold-off on request.
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req && hold_left == 0)
                hold_left = 400;
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
                if (hold_left == 0)
                    hold_req = 1'b0;
            end
            else
                out_stall <= idle_on && ($urandom_range(99) < 10);
        end
    end

    // Result checker: every accepted result is compared with the oldest
    // expectation.
    always @(posedge clk)
    begin
        rbcl_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_q.size() == 0)
            begin
                $error("result with no expectation: label %0d count %0d done %0d",
                       out_data.pixel_label, out_data.component_count,
                       out_data.frame_done);
                err_count++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (out_data.pixel_label !== want.pixel_label)
                begin
                    $error("pixel_label expected %0d actual %0d",
                           want.pixel_label, out_data.pixel_label);
                    err_count++;
                end
                if (out_data.component_count !== want.component_count)
                begin
                    $error("component_count expected %0d actual %0d",
                           want.component_count, out_data.component_count);
                    err_count++;
                end
                if (out_data.frame_done !== want.frame_done)
                begin
                    $error("frame_done expected %0d actual %0d",
                           want.frame_done, out_data.frame_done);
                    err_count++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic stim_row_t row_item(logic op, logic px, int r, int c,
                                           logic has_exp, int lbl, int cnt, logic done);
        stim_row_t s;
        s.kind                  = ROW_ITEM;
        s.item.operation        = op;
        s.item.pixel_value      = px;
        s.item.read_row         = 8'(r);
        s.item.read_column      = 8'(c);
        s.has_exp               = has_exp;
        s.exp.pixel_label       = 16'(lbl);
        s.exp.component_count   = 16'(cnt);
        s.exp.frame_done        = done;
        s.reg_idx               = '0;
        s.reg_val               = '0;
        return s;
    endfunction

    function automatic stim_row_t row_cfg(logic [1:0] idx, logic [8:0] val);
        stim_row_t s;
        s         = row_item(OP_PUSH, 1'b0, 0, 0, 1'b0, 0, 0, 1'b0);
        s.kind    = ROW_CFG;
        s.reg_idx = idx;
        s.reg_val = val;
        return s;
    endfunction

    initial
    begin
        stim_row_t  stim_table[$];
        logic [1:0] reg_w;
        logic [1:0] reg_h;
        int         i, n_items, phase;

        reg_w = {1'b0, REG_FRAME_WIDTH};
        reg_h = {1'b0, REG_FRAME_HEIGHT};

        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        out_stall   = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        err_count   = 0;
        cycle_count = 0;
        idle_on     = 1'b1;
        hold_req    = 1'b0;

        frame_w_reg = 9'd256;
        frame_h_reg = 9'd256;
        label_ctr   = 0;
        last_pixel  = 0;
        run_ctr     = 0;
        pixel_pos   = 0;
        comp_count  = 0;
        frame_ready = 1'b0;

        // Directed part. After reset nothing is resolved, so reads give 0.
        stim_table.push_back(row_item(OP_READ, 1'b1, 0, 0, 1'b1, 0, 0, 1'b0));
        stim_table.push_back(row_item(OP_READ, 1'b0, 255, 255, 1'b1, 0, 0, 1'b0));
        // A push into the default 256 x 256 frame completes nothing.
        stim_table.push_back(row_item(OP_PUSH, 1'b1, 255, 255, 1'b1, 0, 0, 1'b0));
        // Size zero counts as one: a 1 x 1 frame is finished by each push.
        stim_table.push_back(row_cfg(reg_w, 9'd0));
        stim_table.push_back(row_cfg(reg_h, 9'd0));
        stim_table.push_back(row_item(OP_PUSH, 1'b1, 0, 0, 1'b1, 0, 1, 1'b1));
        stim_table.push_back(row_item(OP_READ, 1'b0, 0, 0, 1'b1, 1, 1, 1'b0));
        // Reads outside the frame return background.
        stim_table.push_back(row_item(OP_READ, 1'b0, 0, 1, 1'b1, 0, 1, 1'b0));
        stim_table.push_back(row_item(OP_READ, 1'b0, 1, 0, 1'b1, 0, 1, 1'b0));
        stim_table.push_back(row_item(OP_PUSH, 1'b0, 0, 0, 1'b1, 0, 0, 1'b1));
        stim_table.push_back(row_item(OP_READ, 1'b1, 0, 0, 1'b1, 0, 0, 1'b0));
        // A 5 x 2 frame: runs that touch only at a corner still merge.
        stim_table.push_back(row_cfg(reg_w, 9'd5));
        stim_table.push_back(row_cfg(reg_h, 9'd2));
        stim_table.push_back(row_item(OP_PUSH, 1'b1, 0, 0, 1'b0, 0, 0, 1'b0));
        stim_table.push_back(row_item(OP_PUSH, 1'b0, 0, 0, 1'b0, 0, 0, 1'b0));
        // A read during acquisition sees no resolved frame.
        stim_table.push_back(row_item(OP_READ, 1'b0, 0, 0, 1'b1, 0, 0, 1'b0));
        stim_table.push_back(row_item(OP_PUSH, 1'b0, 0, 0, 1'b0, 0, 0, 1'b0));
        stim_table.push_back(row_item(OP_PUSH, 1'b1, 0, 0, 1'b0, 0, 0, 1'b0));
        stim_table.push_back(row_item(OP_PUSH, 1'b1, 0, 0, 1'b0, 0, 0, 1'b0));
        stim_table.push_back(row_item(OP_PUSH, 1'b0, 0, 0, 1'b0, 0, 0, 1'b0));
        stim_table.push_back(row_item(OP_PUSH, 1'b1, 0, 0, 1'b0, 0, 0, 1'b0));
        stim_table.push_back(row_item(OP_PUSH, 1'b1, 0, 0, 1'b0, 0, 0, 1'b0));
        stim_table.push_back(row_item(OP_PUSH, 1'b0, 0, 0, 1'b0, 0, 0, 1'b0));
        stim_table.push_back(row_item(OP_PUSH, 1'b0, 0, 0, 1'b0, 0, 0, 1'b0));
        stim_table.push_back(row_item(OP_READ, 1'b0, 0, 0, 1'b0, 0, 0, 1'b0));
        stim_table.push_back(row_item(OP_READ, 1'b0, 1, 2, 1'b0, 0, 0, 1'b0));

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (stim_table[i])
        begin
            if (stim_table[i].kind == ROW_CFG)
                write_reg(stim_table[i].reg_idx, stim_table[i].reg_val);
            else
                send_item(stim_table[i].item, stim_table[i].has_exp, stim_table[i].exp);
        end

        // Extremes of the frame size: the widest row, the tallest column, and
        // oversized values that saturate to the maximum.
        write_reg(reg_w, 9'd511);
        write_reg(reg_h, 9'd2);
        run_frame(50, 12);
        send_read(1, 255);
        write_reg(reg_w, 9'd256);
        write_reg(reg_h, 9'd1);
        run_frame(70, 6);
        write_reg(reg_w, 9'd2);
        write_reg(reg_h, 9'd300);
        run_frame(40, 10);
        send_read(255, 1);
        write_reg(reg_w, 9'd1);
        write_reg(reg_h, 9'd256);
        run_frame(50, 4);
        send_read(255, 0);

        // Random part: mostly small frames pushed whole, some of them broken
        // off by a size write, with reads of the resolved labels.
        n_items = 0;
        phase   = 0;
        while (n_items < 750)
        begin
            int w, h, density, cut;
            phase++;
            // A stretch with no idling on either side.
            idle_on = !(phase >= 12 && phase < 20);
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 8);
            if ($urandom_range(9) == 0)
                w = $urandom_range(1) ? 0 : $urandom_range(257, 511);
            if ($urandom_range(1))
                write_reg(reg_w, 9'(w));
            write_reg(reg_h, 9'(h));
            density = $urandom_range(100);
            if (phase == 6)
                hold_req = 1'b1;
            if ($urandom_range(7) == 0)
            begin
                // Broken frame: acquisition stops part way.
                cut = $urandom_range(dim_clamp(w, MAX_WIDTH) * h);
                for (i = 0; i < cut; i++)
                    send_push($urandom_range(99) < density);
                send_read($urandom_range(255), $urandom_range(255));
                n_items += cut + 1;
            end
            else
            begin
                run_frame(density, 8);
                n_items += dim_clamp(w, MAX_WIDTH) * h + 8;
            end
        end

        drain();
        if (err_count == 0 && expected_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
